/* sv/jsu_pkg.sv */
// Shared constants, types and helpers for the JSON string unescape block.
package jsu_pkg;

	// Result status codes carried on the master tuser
	localparam logic [2:0] ST_DATA       = 3'd0;
	localparam logic [2:0] ST_CLOSED     = 3'd1;
	localparam logic [2:0] ST_UNTERM_STR = 3'd2;
	localparam logic [2:0] ST_UNTERM_ESC = 3'd3;
	localparam logic [2:0] ST_TRUNC_UNI  = 3'd4;
	localparam logic [2:0] ST_BAD_HEX    = 3'd5;
	localparam logic [2:0] ST_UNK_ESC    = 3'd6;

	// Characters with a meaning inside a string body
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Control bytes produced by the single-letter escapes
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	// UTF-8 range limits and lead/continuation marks
	localparam logic [15:0] UTF_MAX1  = 16'h007F;
	localparam logic [15:0] UTF_MAX2  = 16'h07FF;
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;
	localparam logic [7:0]  UTF_MASK6 = 8'h3F;

	// Hex digit lookup result
	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Decode one ASCII hex digit of either case
	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t r;
		r.ok    = 1'b1;
		r.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.value = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r.value = b[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

/* sv/json_string_unescape.sv */
// Streaming unescape of a JSON string body into raw bytes and UTF-8.
//
// Channel | Dir | tdata          | tuser           | tlast
// s_*     | in  | text_byte[7:0] | end_of_text     | -
// m_*     | out | out_byte[7:0]  | status[2:0]     | last_of_run
//
// One input item per cycle while m_tready keeps the result group draining. Decode is
// one combinational pass from the port into a three-entry result group register; the
// final digit of a \u escape fills up to three entries, so the next item waits while
// the group drains one result per cycle, and longer while m_tready is low.
// arst_n clears decode mode, hex count and accumulator and empties the result group.
// A stalled m_tready holds the group; s_tready rises as its last entry leaves.
module json_string_unescape (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tuser,   // [0] end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [2:0] status
	output logic       m_tlast
);

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX   = 2'd2
	} mode_t;

	mode_t       mode_q;
	logic [1:0]  hex_cnt_q;
	logic [15:0] acc_q;

	logic [1:0]  grp_cnt_s1;
	logic [1:0]  grp_idx_s1;
	logic [7:0]  grp_b0_s1, grp_b1_s1, grp_b2_s1;
	logic [2:0]  grp_status_s1;

	mode_t       nxt_mode;
	logic [1:0]  nxt_hex_cnt;
	logic [15:0] nxt_acc;
	logic [1:0]  res_cnt;
	logic [7:0]  res_b0, res_b1, res_b2;
	logic [2:0]  res_status;

	jsu_pkg::hex_digit_t hd;
	logic [15:0] code;
	logic        load;
	logic        take;

	assign hd   = jsu_pkg::hex_decode(s_tdata);
	assign code = {acc_q[11:0], hd.value};

	// Decode one item against the current mode
	always_comb begin
		nxt_mode    = mode_q;
		nxt_hex_cnt = hex_cnt_q;
		nxt_acc     = acc_q;
		res_cnt     = 2'd0;
		res_b0      = 8'h00;
		res_b1      = 8'h00;
		res_b2      = 8'h00;
		res_status  = jsu_pkg::ST_DATA;
		if (s_tuser) begin
			nxt_mode    = MODE_PLAIN;
			nxt_hex_cnt = 2'd0;
			nxt_acc     = 16'h0000;
			res_cnt     = 2'd1;
			unique case (mode_q)
				MODE_ESC: res_status = jsu_pkg::ST_UNTERM_ESC;
				MODE_HEX: res_status = jsu_pkg::ST_TRUNC_UNI;
				default:  res_status = jsu_pkg::ST_UNTERM_STR;
			endcase
		end else begin
			unique case (mode_q)
				MODE_ESC: begin
					nxt_mode = MODE_PLAIN;
					res_cnt  = 2'd1;
					unique case (s_tdata) inside
						jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
							res_b0 = s_tdata;
						jsu_pkg::CH_B: res_b0 = jsu_pkg::CTL_BS;
						jsu_pkg::CH_F: res_b0 = jsu_pkg::CTL_FF;
						jsu_pkg::CH_N: res_b0 = jsu_pkg::CTL_LF;
						jsu_pkg::CH_R: res_b0 = jsu_pkg::CTL_CR;
						jsu_pkg::CH_T: res_b0 = jsu_pkg::CTL_HT;
						jsu_pkg::CH_U: begin
							nxt_mode    = MODE_HEX;
							nxt_hex_cnt = 2'd0;
							nxt_acc     = 16'h0000;
							res_cnt     = 2'd0;
						end
						default: begin
							nxt_hex_cnt = 2'd0;
							nxt_acc     = 16'h0000;
							res_status  = jsu_pkg::ST_UNK_ESC;
						end
					endcase
				end
				MODE_HEX: begin
					if (!hd.ok) begin
						nxt_mode    = MODE_PLAIN;
						nxt_hex_cnt = 2'd0;
						nxt_acc     = 16'h0000;
						res_cnt     = 2'd1;
						res_status  = jsu_pkg::ST_BAD_HEX;
					end else if (hex_cnt_q != 2'd3) begin
						nxt_acc     = code;
						nxt_hex_cnt = hex_cnt_q + 2'd1;
					end else begin
						// fourth digit: emit the code as UTF-8
						nxt_mode    = MODE_PLAIN;
						nxt_hex_cnt = 2'd0;
						nxt_acc     = 16'h0000;
						if (code <= jsu_pkg::UTF_MAX1) begin
							res_cnt = 2'd1;
							res_b0  = code[7:0];
						end else if (code <= jsu_pkg::UTF_MAX2) begin
							res_cnt = 2'd2;
							res_b0  = jsu_pkg::UTF_LEAD2 | {3'b000, code[10:6]};
							res_b1  = jsu_pkg::UTF_CONT | ({2'b00, code[5:0]} & jsu_pkg::UTF_MASK6);
						end else begin
							res_cnt = 2'd3;
							res_b0  = jsu_pkg::UTF_LEAD3 | {4'b0000, code[15:12]};
							res_b1  = jsu_pkg::UTF_CONT | ({2'b00, code[11:6]} & jsu_pkg::UTF_MASK6);
							res_b2  = jsu_pkg::UTF_CONT | ({2'b00, code[5:0]} & jsu_pkg::UTF_MASK6);
						end
					end
				end
				default: begin
					nxt_mode = MODE_PLAIN;
					if (s_tdata == jsu_pkg::CH_QUOTE) begin
						nxt_hex_cnt = 2'd0;
						nxt_acc     = 16'h0000;
						res_cnt     = 2'd1;
						res_status  = jsu_pkg::ST_CLOSED;
					end else if (s_tdata == jsu_pkg::CH_BSLASH) begin
						nxt_mode    = MODE_ESC;
						nxt_hex_cnt = 2'd0;
						nxt_acc     = 16'h0000;
					end else begin
						res_cnt = 2'd1;
						res_b0  = s_tdata;
					end
				end
			endcase
		end
	end

	// Output side of the result group
	assign m_tvalid = (grp_cnt_s1 != 2'd0);
	assign m_tlast  = (grp_idx_s1 == (grp_cnt_s1 - 2'd1));
	assign m_tuser  = grp_status_s1;

	always_comb begin
		case (grp_idx_s1)
			2'd1:    m_tdata = grp_b1_s1;
			2'd2:    m_tdata = grp_b2_s1;
			default: m_tdata = grp_b0_s1;
		endcase
	end

	// Accept while the group is empty or its last entry leaves now
	assign s_tready = (grp_cnt_s1 == 2'd0) || (m_tready && m_tlast);
	assign load     = s_tvalid && s_tready;
	assign take     = m_tvalid && m_tready;

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			hex_cnt_q <= 2'd0;
			acc_q     <= 16'h0000;
		end else if (load) begin
			mode_q    <= nxt_mode;
			hex_cnt_q <= nxt_hex_cnt;
			acc_q     <= nxt_acc;
		end
	end

	// Result group control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_s1 <= 2'd0;
			grp_idx_s1 <= 2'd0;
		end else if (load) begin
			grp_cnt_s1 <= res_cnt;
			grp_idx_s1 <= 2'd0;
		end else if (take) begin
			if (m_tlast) begin
				grp_cnt_s1 <= 2'd0;
				grp_idx_s1 <= 2'd0;
			end else begin
				grp_idx_s1 <= grp_idx_s1 + 2'd1;
			end
		end
	end

	// Result group payload
	always_ff @(posedge clk) begin
		if (load) begin
			grp_b0_s1     <= res_b0;
			grp_b1_s1     <= res_b1;
			grp_b2_s1     <= res_b2;
			grp_status_s1 <= res_status;
		end
	end

	// Non-data statuses always come alone
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != jsu_pkg::ST_DATA) |-> m_tlast && (grp_idx_s1 == 2'd0))
		else $error("status result not alone in its group");

	// Later entries of a group are UTF-8 continuation bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (grp_idx_s1 != 2'd0) |-> (m_tdata[7:6] == 2'b10))
		else $error("non-continuation byte after lead");

	// Hex digits are only counted inside a \u escape
	assert property (@(posedge clk) disable iff (!arst_n)
		(hex_cnt_q != 2'd0) |-> (mode_q == MODE_HEX))
		else $error("hex count outside hex mode");

	// A pending group is never overwritten before its last entry is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		load && m_tvalid |-> m_tready && m_tlast)
		else $error("result group overwritten");

endmodule

/* sim/jsu_decode_monitor.sv */
// Channel monitor for the JSON string unescape block: predicts decoded results and compares them.
module jsu_decode_monitor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tuser,   // [0] end_of_text
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic [2:0] m_tuser,   // [2:0] status
	input  logic       m_tlast,
	output int         mismatch_count,
	output int         results_pending
);

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_ESCAPE,
		MODE_HEX,
		MODE_SPARE
	} decode_mode_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last_of_run;
	} decoded_t;

	// Shadow decoder state
	decode_mode_t mode;
	logic [1:0]   digits_seen;
	logic [15:0]  code_acc;

	decoded_t expected_results[$];

	// {valid, value} of one ASCII hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39)
			return {1'b1, b[3:0]};
		if (b >= 8'h61 && b <= 8'h66)
			return {1'b1, 4'(b - 8'h57)};
		if (b >= 8'h41 && b <= 8'h46)
			return {1'b1, 4'(b - 8'h37)};
		return 5'd0;
	endfunction

	task automatic push_result(input logic [7:0] b, input logic [2:0] st, input logic last);
		decoded_t r;
		r.out_byte    = b;
		r.status      = st;
		r.last_of_run = last;
		expected_results.insert(expected_results.size(), r);
	endtask

	// Any close, end or error: one status result, decoder back to idle
	task automatic end_string(input logic [2:0] st);
		mode        = MODE_PLAIN;
		digits_seen = 2'd0;
		code_acc    = 16'd0;
		push_result(8'h00, st, 1'b1);
	endtask

	// Work out the results caused by one accepted text item
	task automatic decode_text_byte(input logic [7:0] b, input logic eot);
		logic [4:0]  nib;
		logic [15:0] code;
		if (eot) begin
			case (mode)
				MODE_ESCAPE: end_string(jsu_pkg::ST_UNTERM_ESC);
				MODE_HEX:    end_string(jsu_pkg::ST_TRUNC_UNI);
				default:     end_string(jsu_pkg::ST_UNTERM_STR);
			endcase
		end else if (mode == MODE_ESCAPE) begin
			mode = MODE_PLAIN;
			case (b)
				jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
					push_result(b, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_B: push_result(jsu_pkg::CTL_BS, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_F: push_result(jsu_pkg::CTL_FF, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_N: push_result(jsu_pkg::CTL_LF, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_R: push_result(jsu_pkg::CTL_CR, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_T: push_result(jsu_pkg::CTL_HT, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_U: begin
					mode        = MODE_HEX;
					digits_seen = 2'd0;
					code_acc    = 16'd0;
				end
				default: end_string(jsu_pkg::ST_UNK_ESC);
			endcase
		end else if (mode == MODE_HEX) begin
			nib  = hex_nibble(b);
			code = {code_acc[11:0], nib[3:0]};
			if (!nib[4]) begin
				end_string(jsu_pkg::ST_BAD_HEX);
			end else if (digits_seen != 2'd3) begin
				code_acc    = code;
				digits_seen = digits_seen + 2'd1;
			end else begin
				mode        = MODE_PLAIN;
				digits_seen = 2'd0;
				code_acc    = 16'd0;
				// UTF-8 of one, two or three bytes
				if (code <= jsu_pkg::UTF_MAX1) begin
					push_result(code[7:0], jsu_pkg::ST_DATA, 1'b1);
				end else if (code <= jsu_pkg::UTF_MAX2) begin
					push_result(jsu_pkg::UTF_LEAD2 | {3'b000, code[10:6]},
						jsu_pkg::ST_DATA, 1'b0);
					push_result(jsu_pkg::UTF_CONT | {2'b00, code[5:0]},
						jsu_pkg::ST_DATA, 1'b1);
				end else begin
					push_result(jsu_pkg::UTF_LEAD3 | {4'h0, code[15:12]},
						jsu_pkg::ST_DATA, 1'b0);
					push_result(jsu_pkg::UTF_CONT | {2'b00, code[11:6]},
						jsu_pkg::ST_DATA, 1'b0);
					push_result(jsu_pkg::UTF_CONT | {2'b00, code[5:0]},
						jsu_pkg::ST_DATA, 1'b1);
				end
			end
		end else begin
			// plain mode, spare mode value included
			if (b == jsu_pkg::CH_QUOTE) begin
				end_string(jsu_pkg::ST_CLOSED);
			end else if (b == jsu_pkg::CH_BSLASH) begin
				mode        = MODE_ESCAPE;
				digits_seen = 2'd0;
				code_acc    = 16'd0;
			end else begin
				mode = MODE_PLAIN;
				push_result(b, jsu_pkg::ST_DATA, 1'b1);
			end
		end
	endtask

	// Compare outgoing items first; an input accepted on this edge cannot cause them
	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t want;
		if (!arst_n) begin
			mode           = MODE_PLAIN;
			digits_seen    = 2'd0;
			code_acc       = 16'd0;
			mismatch_count = 0;
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: out_byte %h status %0d last_of_run %0b",
						m_tdata, m_tuser, m_tlast);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata !== want.out_byte) begin
						$error("out_byte: expected %h, actual %h", want.out_byte, m_tdata);
						mismatch_count++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tuser);
						mismatch_count++;
					end
					if (m_tlast !== want.last_of_run) begin
						$error("last_of_run: expected %0b, actual %0b", want.last_of_run, m_tlast);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_text_byte(s_tdata, s_tuser);
		end
		results_pending = expected_results.size();
	end

endmodule

/* sim/tb_top.sv */
// Top of the unescape testbench: clock, reset, text stimulus, result sink and verdict.
module tb_top;

	localparam int IDLE_LIMIT  = 2000;
	localparam int ITEM_TARGET = 470;
	localparam int LONG_STALL  = 300;
	localparam int DRAIN_WAIT  = 20;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] text_byte
	logic       s_tuser;   // [0] end_of_text
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic [2:0] m_tuser;   // [2:0] status
	logic       m_tlast;

	int mismatch_count;
	int results_pending;
	int idle_cycles;

	text_item_t text_items[$];
	bit         hold_request;
	bit         sender_busy_run;
	bit         receiver_busy_run;

	json_string_unescape dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	jsu_decode_monitor u_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Text building helpers
	function automatic void add_byte(input logic [7:0] b);
		text_item_t it;
		it.text_byte   = b;
		it.end_of_text = 1'b0;
		text_items.insert(text_items.size(), it);
	endfunction

	function automatic void add_eot();
		text_item_t it;
		it.text_byte   = 8'($urandom);
		it.end_of_text = 1'b1;
		text_items.insert(text_items.size(), it);
	endfunction

	function automatic bit is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66);
	endfunction

	// Hex digit character, letters in either case
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + {4'h0, n};
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
	endfunction

	function automatic void add_digits(input logic [15:0] code, input int count);
		for (int i = 0; i < count; i++)
			add_byte(hex_char(code[(3 - i) * 4 +: 4]));
	endfunction

	function automatic void add_unicode(input logic [15:0] code);
		add_byte(jsu_pkg::CH_BSLASH);
		add_byte(jsu_pkg::CH_U);
		add_digits(code, 4);
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (is_hex(b));
		return b;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] unknown_escape_byte();
		logic [7:0] b;
		do b = 8'($urandom);
		while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH || b == jsu_pkg::CH_SLASH ||
			b == jsu_pkg::CH_B || b == jsu_pkg::CH_F || b == jsu_pkg::CH_N ||
			b == jsu_pkg::CH_R || b == jsu_pkg::CH_T || b == jsu_pkg::CH_U);
		return b;
	endfunction

	function automatic logic [7:0] simple_escape_byte();
		case ($urandom_range(0, 7))
			0: return jsu_pkg::CH_QUOTE;
			1: return jsu_pkg::CH_BSLASH;
			2: return jsu_pkg::CH_SLASH;
			3: return jsu_pkg::CH_B;
			4: return jsu_pkg::CH_F;
			5: return jsu_pkg::CH_N;
			6: return jsu_pkg::CH_R;
			default: return jsu_pkg::CH_T;
		endcase
	endfunction

	// Codes spread over the one, two and three byte ranges and their edges, plus the surrogate range
	function automatic logic [15:0] random_code();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(16'h0000, jsu_pkg::UTF_MAX1));
			1: return 16'($urandom_range(16'h0080, jsu_pkg::UTF_MAX2));
			2: return 16'($urandom_range(16'h0800, 16'hFFFF));
			3: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return jsu_pkg::UTF_MAX1;
					2: return 16'h0080;
					3: return jsu_pkg::UTF_MAX2;
					4: return 16'h0800;
					default: return 16'hFFFF;
				endcase
			end
			4: return 16'($urandom_range(16'hD800, 16'hDFFF));
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly well-formed string content, some broken escapes and raw noise
	function automatic void add_random_sequence();
		int sel;
		sel = $urandom_range(0, 39);
		if (sel < 12) begin
			add_byte(plain_byte());
		end else if (sel < 18) begin
			add_byte(jsu_pkg::CH_BSLASH);
			add_byte(simple_escape_byte());
		end else if (sel < 26) begin
			add_unicode(random_code());
		end else if (sel < 28) begin
			add_byte(jsu_pkg::CH_QUOTE);
		end else if (sel < 31) begin
			// text ends in plain, escape or hex state
			case ($urandom_range(0, 2))
				0: ;
				1: add_byte(jsu_pkg::CH_BSLASH);
				default: begin
					add_byte(jsu_pkg::CH_BSLASH);
					add_byte(jsu_pkg::CH_U);
					add_digits(16'($urandom), $urandom_range(0, 3));
				end
			endcase
			add_eot();
		end else if (sel < 34) begin
			add_byte(jsu_pkg::CH_BSLASH);
			add_byte(jsu_pkg::CH_U);
			add_digits(16'($urandom), $urandom_range(0, 3));
			add_byte(non_hex_byte());
		end else if (sel < 36) begin
			add_byte(jsu_pkg::CH_BSLASH);
			add_byte(unknown_escape_byte());
		end else begin
			if ($urandom_range(0, 7) == 0)
				add_eot();
			else
				add_byte(8'($urandom));
		end
	endfunction

	// Offer one item after a random gap; returns at the falling edge after acceptance
	task automatic send_item(input text_item_t it);
		int gap;
		if ($urandom_range(0, 29) == 0)
			sender_busy_run = ~sender_busy_run;
		gap = sender_busy_run ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it.text_byte;
		s_tuser  <= it.end_of_text;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stimulus and verdict
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes, two and three byte codes, every end and error
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(jsu_pkg::CH_BSLASH);
		add_byte(jsu_pkg::CH_U);
		add_byte(8'h30);
		add_byte(8'h37);
		add_byte(8'h66);
		add_byte(8'h46);
		add_unicode(16'hD800);
		add_byte(jsu_pkg::CH_BSLASH);
		add_byte(jsu_pkg::CH_N);
		add_byte(jsu_pkg::CH_QUOTE);
		add_eot();
		add_byte(jsu_pkg::CH_BSLASH);
		add_eot();
		add_byte(jsu_pkg::CH_BSLASH);
		add_byte(jsu_pkg::CH_U);
		add_byte(8'h30);
		add_eot();
		add_byte(jsu_pkg::CH_BSLASH);
		add_byte(8'h71);
		add_byte(jsu_pkg::CH_BSLASH);
		add_byte(jsu_pkg::CH_U);
		add_byte(8'h47);

		while (text_items.size() < ITEM_TARGET)
			add_random_sequence();

		for (int i = 0; i < text_items.size(); i++) begin
			// receiver stalls long while items keep coming
			if (i == text_items.size() / 2)
				hold_request = 1'b1;
			send_item(text_items[i]);
		end
		s_tvalid <= 1'b0;

		while (results_pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0 && results_pending == 0)
			$display("** json_string_unescape: PASSED **");
		else
			$display("** json_string_unescape: FAILED **");
		$finish;
	end

	// Result sink with random stalls and one long hold-off
	initial begin : result_sink
		int gap;
		bit hold_done;
		m_tready  = 1'b0;
		hold_done = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				receiver_busy_run = ~receiver_busy_run;
			gap = receiver_busy_run ? 0 : $urandom_range(0, 10);
			if (hold_request && !hold_done) begin
				gap       = LONG_STALL;
				hold_done = 1'b1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** json_string_unescape: FAILED **");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
